FILE: hdl/utf8_to_utf16_stream_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core_macros
// assertion macros shared by the decoder modules, clocked on clk_i with
// reset rst_ni
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_CORE_MACROS_SVH

// property holds on every clock edge outside reset
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define U8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/u8u16d_pkg.sv
// ----------------------------------------------------------------------------
// u8u16d_pkg
// types, byte class and transition tables of the utf-8 to utf-16 decoder
// ----------------------------------------------------------------------------
package u8u16d_pkg;

  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_REJECT = 4'd1;
  localparam logic [3:0] ST_LAST   = 4'd8;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic        last_of_run;
    logic [15:0] words_so_far;
  } out_item_t;

  // result of one decode step
  typedef struct packed {
    logic [3:0]  state;
    logic [20:0] accum;
    logic [15:0] count;
    logic [1:0]  n_words;
    out_item_t   word0;
    out_item_t   word1;
  } step_res_t;

  // nibble-packed byte class rows
  localparam logic [31:0] CLASS_ROWS [10] = '{
    32'h00000000, 32'h11111111, 32'h22222222, 32'h33433333, 32'h22222288,
    32'h3333333A, 32'h8885666B, 32'h77777777, 32'h88888888, 32'h99999999
  };

  // class row per group of 8 byte values
  localparam logic [3:0] CLASS_SEL [32] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd1, 4'd1, 4'd9, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd4, 4'd2, 4'd2, 4'd2, 4'd5, 4'd3, 4'd6, 4'd8
  };

  // nibble-packed transition rows
  localparam logic [31:0] TRANS_ROWS [11] = '{
    32'h17853210, 32'h11116411, 32'h11111111, 32'h01111101, 32'h11111101,
    32'h21111121, 32'h11111121, 32'h21111111, 32'h31111111, 32'h11111131,
    32'h31111131
  };

  // transition row per (state, upper class half)
  localparam logic [3:0] TRANS_SEL [18] = '{
    4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd2, 4'd6, 4'd6, 4'd8, 4'd9, 4'd10, 4'd9, 4'd9, 4'd2
  };

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [31:0] row;
    row = CLASS_ROWS[CLASS_SEL[b[7:3]]];
    return row[{b[2:0], 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] next_state(input logic [3:0] st, input logic [3:0] cls);
    logic [4:0]  sel;
    logic [31:0] row;
    sel = {st, cls[3]};
    if (st > ST_LAST) begin
      return ST_REJECT;
    end
    row = TRANS_ROWS[TRANS_SEL[sel]];
    return row[{cls[2:0], 2'b00} +: 4];
  endfunction

endpackage

FILE: hdl/u8u16d_step.sv
// ----------------------------------------------------------------------------
// u8u16d_step
// one decode step: byte class, accumulator, dfa transition and word emission
// ----------------------------------------------------------------------------
module u8u16d_step (
  input  u8u16d_pkg::in_item_t  item_i,
  input  logic [3:0]            state_i,
  input  logic [20:0]           accum_i,
  input  logic [15:0]           count_i,
  input  logic [15:0]           capacity_i,
  output u8u16d_pkg::step_res_t res_o
);
  import u8u16d_pkg::*;

  logic [3:0]  st;
  logic [20:0] acc;
  logic [15:0] cnt;
  logic [3:0]  cls;
  logic [20:0] acc_new;
  logic [3:0]  st_new;
  logic [7:0]  lead_mask;

  always_comb begin
    // string start puts the dfa back to accept before this byte
    st  = item_i.string_start ? ST_ACCEPT : state_i;
    acc = item_i.string_start ? 21'd0 : accum_i;
    cnt = item_i.string_start ? 16'd0 : count_i;

    cls       = byte_class(item_i.byte_value);
    lead_mask = 8'hFF >> cls;
    if (st != ST_ACCEPT) begin
      acc_new = {acc[14:0], item_i.byte_value[5:0]};
    end else begin
      acc_new = {13'd0, lead_mask & item_i.byte_value};
    end
    st_new = next_state(st, cls);

    res_o         = '0;
    res_o.accum   = acc_new;
    res_o.count   = cnt;
    res_o.state   = st_new;
    res_o.n_words = 2'd0;

    if (st_new == ST_ACCEPT && cnt < capacity_i) begin
      if (acc_new > 21'h00FFFF) begin
        if ({1'b0, cnt} + 17'd2 > {1'b0, capacity_i}) begin
          // no room for the pair: drop it and stop this string
          res_o.state = ST_REJECT;
        end else begin
          res_o.n_words            = 2'd2;
          res_o.word0.word_value   = 16'hD7C0 + {5'd0, acc_new[20:10]};
          res_o.word0.last_of_run  = 1'b0;
          res_o.word0.words_so_far = cnt + 16'd1;
          res_o.word1.word_value   = 16'hDC00 + {6'd0, acc_new[9:0]};
          res_o.word1.last_of_run  = 1'b1;
          res_o.word1.words_so_far = cnt + 16'd2;
          res_o.count              = cnt + 16'd2;
        end
      end else begin
        res_o.n_words            = 2'd1;
        res_o.word0.word_value   = acc_new[15:0];
        res_o.word0.last_of_run  = 1'b1;
        res_o.word0.words_so_far = cnt + 16'd1;
        res_o.count              = cnt + 16'd1;
      end
    end
  end

endmodule

FILE: hdl/u8u16d_ofifo.sv
// ----------------------------------------------------------------------------
// u8u16d_ofifo
// small result queue: takes up to two words per cycle, hands out one
// ----------------------------------------------------------------------------
module u8u16d_ofifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_n_i,
  input  u8u16d_pkg::out_item_t word0_i,
  input  u8u16d_pkg::out_item_t word1_i,
  output logic                  room2_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u8u16d_pkg::out_item_t out_item_o
);
  import u8u16d_pkg::*;
  `include "utf8_to_utf16_stream_decoder_core_macros.svh"

  out_item_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign room2_o     = (cnt_q <= CntW'(FifoDepth - 2));
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_n_i);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= word0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= word1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `U8D_ASSERT(a_no_overflow, cnt_q <= CntW'(FifoDepth), "result queue over depth")
  `U8D_ASSERT(a_pair_fits, push_n_i != 2'd2 || room2_o, "word pair pushed without room")
  `U8D_ASSERT_NEXT(a_ptr_gap, 1'b1, PtrW'(wr_q - rd_q) == PtrW'(cnt_q), "queue pointers out of step")

endmodule

FILE: hdl/utf8_to_utf16_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core
// utf-8 byte stream in, utf-16 code units out, with per-string word limit
// ----------------------------------------------------------------------------
// an accepted byte is held in the input register, then decoded into the result
//   queue, which drives out_valid_o
// throughput: one byte per cycle; the decode stage stalls only while the
//   four-word result queue has fewer than two free slots
// reset: dfa in accept, accumulator and word count zero, capacity 65535,
//   input register and result queue empty
module utf8_to_utf16_stream_decoder_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  u8u16d_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u8u16d_pkg::out_item_t out_item_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);
  import u8u16d_pkg::*;
  `include "utf8_to_utf16_stream_decoder_core_macros.svh"

  // input register
  logic      in_valid_q;
  in_item_t  in_item_q;

  // decoder state
  logic [3:0]  state_q;
  logic [20:0] accum_q;
  logic [15:0] count_q;
  logic [15:0] cap_q;

  step_res_t res;
  logic      room2;
  logic      fire;
  logic [1:0] push_n;

  // the held byte is decoded once the queue can take a full pair
  assign fire       = in_valid_q & room2;
  assign in_ready_o = ~in_valid_q | fire;
  assign push_n     = fire ? res.n_words : 2'd0;

  u8u16d_step u_step (
    .item_i     (in_item_q),
    .state_i    (state_q),
    .accum_i    (accum_q),
    .count_i    (count_q),
    .capacity_i (cap_q),
    .res_o      (res)
  );

  u8u16d_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .word0_i     (res.word0),
    .word1_i     (res.word1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // payload of the input register, loaded on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= ST_ACCEPT;
      accum_q    <= '0;
      count_q    <= '0;
      cap_q      <= 16'hFFFF;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      // dfa, accumulator and count advance once per decoded byte
      if (fire) begin
        state_q <= res.state;
        accum_q <= res.accum;
        count_q <= res.count;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  `U8D_ASSERT(a_state_range, state_q <= ST_LAST, "dfa state outside its nine states")
  `U8D_ASSERT_NEXT(a_hold_byte, in_valid_q && !fire, in_valid_q, "held byte lost before decode")
  `U8D_ASSERT_NEXT(a_reject_sticky, fire && res.state == ST_REJECT,
                   state_q == ST_REJECT, "reject not kept")

endmodule
